@@ rtl/core/playfair_digraph_decrypt_macros.svh @@
// Assertion macros shared by the playfair decryptor RTL.
`ifndef PLAYFAIR_DIGRAPH_DECRYPT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_DECRYPT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdd assertion failed");

// Next-cycle implication, checked outside reset.
`define PDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdd assertion failed");

`endif

@@ rtl/core/pdd_pkg.sv @@
// Types, constants and square lookup functions for the playfair decryptor.
package pdd_pkg;

	localparam int LETTER_W = 5;
	localparam int SIDE     = 5;
	localparam int CELLS    = SIDE * SIDE;
	localparam int SQ_W     = LETTER_W * CELLS;
	localparam int POS_W    = 3;
	localparam int ROWS2_W  = 2 * SIDE * LETTER_W;
	localparam int ROW1_W   = SIDE * LETTER_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [LETTER_W-1:0] CODE_I    = 5'd8;
	localparam logic [LETTER_W-1:0] CODE_J    = 5'd9;
	localparam logic [LETTER_W-1:0] PAD_RESET = 5'd23;

	// default square "secur ityab dfghk lmnop qvwxz"
	localparam logic [ROWS2_W-1:0] ROWS01_RESET = 50'd36029693823122;
	localparam logic [ROWS2_W-1:0] ROWS23_RESET = 50'd543618685442211;
	localparam logic [ROW1_W-1:0]  ROW4_RESET   = 25'd26991280;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS01 = 2'd0,
		CFG_ROWS23 = 2'd1,
		CFG_ROW4   = 2'd2,
		CFG_PAD    = 2'd3
	} cfg_idx_t;

	// PAIR: two results; PAD1: first result only; PAD2: first result twice
	typedef enum logic [1:0] {
		JOB_PAIR = 2'd0,
		JOB_PAD1 = 2'd1,
		JOB_PAD2 = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic [LETTER_W-1:0] a;
		logic [LETTER_W-1:0] b;
		job_kind_t           kind;
		logic                fin;
	} job_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	// j folds onto i; highest matching entry wins; no match is row 0 col 0
	function automatic pos_t locate(logic [SQ_W-1:0] sq, logic [LETTER_W-1:0] letter);
		pos_t                pos;
		logic [LETTER_W-1:0] l;
		l = (letter == CODE_J) ? CODE_I : letter;
		pos = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (sq[LETTER_W*(SIDE*r+c) +: LETTER_W] == l) begin
					pos.row = POS_W'(r);
					pos.col = POS_W'(c);
				end
			end
		end
		return pos;
	endfunction

	function automatic logic [LETTER_W-1:0] cell_at(logic [SQ_W-1:0] sq,
			logic [POS_W-1:0] row, logic [POS_W-1:0] col);
		logic [LETTER_W-1:0] v;
		v = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (row == POS_W'(r) && col == POS_W'(c)) begin
					v = sq[LETTER_W*(SIDE*r+c) +: LETTER_W];
				end
			end
		end
		return v;
	endfunction

	function automatic logic [POS_W-1:0] wrap_dec(logic [POS_W-1:0] v);
		return (v == '0) ? POS_W'(SIDE - 1) : v - POS_W'(1);
	endfunction

endpackage

@@ rtl/core/pdd_front.sv @@
// Front end: letter pairing, pending-letter state and job generation.
`include "playfair_digraph_decrypt_macros.svh"

module pdd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [pdd_pkg::LETTER_W-1:0]  cipher_letter,
	input  logic                          end_of_text,
	input  logic [pdd_pkg::LETTER_W-1:0]  pad_letter,
	output logic                          push,
	output pdd_pkg::job_t                 job
);

	logic [pdd_pkg::LETTER_W-1:0] held_q;
	logic                         held_valid_q;
	logic                         same;

	assign same = (held_q == cipher_letter);

	always_comb begin
		push     = 1'b0;
		job.a    = held_q;
		job.b    = cipher_letter;
		job.kind = pdd_pkg::JOB_PAIR;
		job.fin  = end_of_text;
		if (!held_valid_q) begin
			// lone final letter pairs with the pad
			job.a    = cipher_letter;
			job.b    = pad_letter;
			job.kind = pdd_pkg::JOB_PAD1;
			push     = accept && end_of_text;
		end else if (same) begin
			// doubled letter: first goes with the pad; if final, so does the second
			job.b    = pad_letter;
			job.kind = end_of_text ? pdd_pkg::JOB_PAD2 : pdd_pkg::JOB_PAD1;
			push     = accept;
		end else begin
			push     = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				held_valid_q <= 1'b0;
				held_q       <= '0;
			end else if (!held_valid_q || same) begin
				held_valid_q <= 1'b1;
				held_q       <= cipher_letter;
			end else begin
				held_valid_q <= 1'b0;
				held_q       <= '0;
			end
		end
	end

	`PDD_ASSERT_NEXT(a_final_clears_held, clk, arst_n, accept && end_of_text, !held_valid_q)

endmodule

@@ rtl/core/pdd_job_fifo.sv @@
// Short job queue between the front end and the decrypt back end.
`include "playfair_digraph_decrypt_macros.svh"

module pdd_job_fifo #(
	parameter int DEPTH = pdd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pdd_pkg::job_t wr_job,
	input  logic          pop,
	output logic          rd_valid,
	output pdd_pkg::job_t rd_job,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pdd_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rd_valid = (count_q != '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`PDD_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full || pop)
	`PDD_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, rd_valid)

endmodule

@@ rtl/core/pdd_back.sv @@
// Back end: square lookup, playfair rules and result serialization.
`include "playfair_digraph_decrypt_macros.svh"

module pdd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pdd_pkg::SQ_W-1:0]      square,
	input  logic                          job_valid,
	input  pdd_pkg::job_t                 job,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pdd_pkg::LETTER_W-1:0]  plain_letter,
	output logic                          final_result
);

	pdd_pkg::pos_t pos_a, pos_b;

	// stage 1: located positions
	logic                 valid_s1;
	pdd_pkg::pos_t        pa_s1, pb_s1;
	pdd_pkg::job_kind_t   kind_s1;
	logic                 fin_s1;

	// stage 2: decrypted letters, drained one per handshake
	logic                          valid_s2;
	logic [pdd_pkg::LETTER_W-1:0]  p0_s2, p1_s2;
	logic                          two_s2;
	logic                          fin_s2;
	logic                          idx_q;

	logic [pdd_pkg::POS_W-1:0]     ra, ca, rb, cb;
	logic [pdd_pkg::LETTER_W-1:0]  p0, p1;
	logic                          take, last, s2_free, adv_s1;

	assign pos_a = pdd_pkg::locate(square, job.a);
	assign pos_b = pdd_pkg::locate(square, job.b);

	assign out_valid    = valid_s2;
	assign plain_letter = idx_q ? p1_s2 : p0_s2;
	assign last         = !two_s2 || idx_q;
	assign final_result = last && fin_s2;
	assign take         = valid_s2 && !out_stall;
	assign s2_free      = !valid_s2 || (take && last);
	assign adv_s1       = valid_s1 && s2_free;
	assign pop          = job_valid && (!valid_s1 || s2_free);

	always_comb begin
		ra = pa_s1.row;
		ca = pa_s1.col;
		rb = pb_s1.row;
		cb = pb_s1.col;
		if (pa_s1.row == pb_s1.row) begin
			p0 = pdd_pkg::cell_at(square, ra, pdd_pkg::wrap_dec(ca));
			p1 = pdd_pkg::cell_at(square, rb, pdd_pkg::wrap_dec(cb));
		end else if (pa_s1.col == pb_s1.col) begin
			p0 = pdd_pkg::cell_at(square, pdd_pkg::wrap_dec(ra), ca);
			p1 = pdd_pkg::cell_at(square, pdd_pkg::wrap_dec(rb), cb);
		end else begin
			p0 = pdd_pkg::cell_at(square, ra, cb);
			p1 = pdd_pkg::cell_at(square, rb, ca);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pa_s1   <= pos_a;
			pb_s1   <= pos_b;
			kind_s1 <= job.kind;
			fin_s1  <= job.fin;
		end
		if (adv_s1) begin
			p0_s2  <= p0;
			fin_s2 <= fin_s1;
			case (kind_s1)
				pdd_pkg::JOB_PAIR: begin
					p1_s2  <= p1;
					two_s2 <= 1'b1;
				end
				pdd_pkg::JOB_PAD2: begin
					p1_s2  <= p0;
					two_s2 <= 1'b1;
				end
				default: begin
					p1_s2  <= p1;
					two_s2 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q    <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				idx_q    <= 1'b0;
			end else if (take && last) begin
				valid_s2 <= 1'b0;
				idx_q    <= 1'b0;
			end else if (take) begin
				idx_q    <= 1'b1;
			end
		end
	end

	`PDD_ASSERT_NOW(a_idx_only_on_pairs, clk, arst_n, valid_s2 && idx_q, two_s2)

endmodule

@@ rtl/core/playfair_digraph_decrypt.sv @@
// Top level of the playfair digraph decryptor.
// A result passes through the job queue, then the stage-1 and stage-2 back-end registers.
// Throughput: one letter per cycle in, one result per cycle out (set by the output register),
// each while not stalled. A pair job drains as two results; the job queue absorbs the burst.
// Reset (arst_n low, async): square and pad return to defaults, no letter pending,
// queue and pipeline empty. No clearing pass.
module playfair_digraph_decrypt #(
	parameter int QUEUE_DEPTH = pdd_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// ciphertext letters
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pdd_pkg::LETTER_W-1:0]    cipher_letter,
	input  logic                            end_of_text,
	// plaintext letters
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pdd_pkg::LETTER_W-1:0]    plain_letter,
	output logic                            final_result,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdd_pkg::ROWS2_W-1:0]     cfg_data
);

	logic [pdd_pkg::ROWS2_W-1:0]   rows01_q;
	logic [pdd_pkg::ROWS2_W-1:0]   rows23_q;
	logic [pdd_pkg::ROW1_W-1:0]    row4_q;
	logic [pdd_pkg::LETTER_W-1:0]  pad_q;
	logic [pdd_pkg::SQ_W-1:0]      square;

	logic          accept;
	logic          push, pop, fifo_valid, fifo_full;
	pdd_pkg::job_t wr_job, rd_job;

	// writes are always taken; config must only change while idle, which the block does not enforce
	assign cfg_ready = 1'b1;
	assign square    = {row4_q, rows23_q, rows01_q};

	// the queue's full flag is the only backpressure on the letter stream
	assign in_stall  = fifo_full;
	assign accept    = in_valid && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows01_q <= pdd_pkg::ROWS01_RESET;
			rows23_q <= pdd_pkg::ROWS23_RESET;
			row4_q   <= pdd_pkg::ROW4_RESET;
			pad_q    <= pdd_pkg::PAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pdd_pkg::cfg_idx_t'(cfg_index))
				pdd_pkg::CFG_ROWS01: rows01_q <= cfg_data;
				pdd_pkg::CFG_ROWS23: rows23_q <= cfg_data;
				pdd_pkg::CFG_ROW4:   row4_q   <= cfg_data[pdd_pkg::ROW1_W-1:0];
				pdd_pkg::CFG_PAD:    pad_q    <= cfg_data[pdd_pkg::LETTER_W-1:0];
				default: ;
			endcase
		end
	end

	// front: pairing and doubled-letter handling, one job per productive letter
	pdd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cipher_letter (cipher_letter),
		.end_of_text   (end_of_text),
		.pad_letter    (pad_q),
		.push          (push),
		.job           (wr_job)
	);

	pdd_job_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.pop      (pop),
		.rd_valid (fifo_valid),
		.rd_job   (rd_job),
		.full     (fifo_full)
	);

	// back: locate, apply row/column/rectangle rule, emit one or two letters
	pdd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.square       (square),
		.job_valid    (fifo_valid),
		.job          (rd_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.plain_letter (plain_letter),
		.final_result (final_result)
	);

endmodule

@@ bench/tb_playfair_digraph_decrypt.sv @@
// Self-checking testbench for the playfair digraph decryptor.
module tb_playfair_digraph_decrypt;
	timeunit 1ns;
	timeprecision 1ps;

	// No item moves for this many cycles: the run is declared hung.
	localparam int IDLE_LIMIT = 1000;
	// Output hold-off used to back the block up onto its input.
	localparam int LONG_HOLD  = 80;
	// Quiet cycles after the last result.
	localparam int SETTLE     = 8;
	// Ring of owed results; far more than the block can hold in flight.
	localparam int OWED_DEPTH = 64;

	typedef struct packed {
		logic [pdd_pkg::LETTER_W-1:0] letter;
		logic                         fin;
	} plain_t;

	logic                         clk;
	logic                         arst_n        = 1'b0;
	logic                         in_valid      = 1'b0;
	logic                         in_stall;
	logic [pdd_pkg::LETTER_W-1:0] cipher_letter = '0;
	logic                         end_of_text   = 1'b0;
	logic                         out_valid;
	logic                         out_stall     = 1'b0;
	logic [pdd_pkg::LETTER_W-1:0] plain_letter;
	logic                         final_result;
	logic                         cfg_valid     = 1'b0;
	logic                         cfg_ready;
	pdd_pkg::cfg_idx_t            cfg_index     = pdd_pkg::CFG_ROWS01;
	logic [pdd_pkg::ROWS2_W-1:0]  cfg_data      = '0;

	// Shadow copy of the block's registers and pairing state.
	logic [pdd_pkg::SQ_W-1:0]     key_sq = {pdd_pkg::ROW4_RESET, pdd_pkg::ROWS23_RESET,
		pdd_pkg::ROWS01_RESET};
	logic [pdd_pkg::LETTER_W-1:0] pad_code = pdd_pkg::PAD_RESET;
	logic [pdd_pkg::LETTER_W-1:0] held_code = '0;
	logic                         held_busy = 1'b0;

	// Plaintext still owed by the block, oldest first.
	plain_t owed_q[OWED_DEPTH];
	int     owed_wr = 0;
	int     owed_rd = 0;

	// Sender pacing and receiver stall controls, set by the tests.
	int gap_max    = 0;
	int burst_left = 0;
	int stall_pct  = 0;
	int hold_token = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int run_left   = 0;
	bit run_stall  = 1'b0;

	// Run statistics.
	int mismatches     = 0;
	int letters_sent   = 0;
	int results_seen   = 0;
	int squares_loaded = 0;
	int backpressured  = 0;
	int idle_cycles    = 0;

	playfair_digraph_decrypt dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cipher_letter(cipher_letter),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.plain_letter (plain_letter),
		.final_result (final_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [pdd_pkg::LETTER_W-1:0] ltr(byte ch);
		return pdd_pkg::LETTER_W'(ch - "a");
	endfunction

	function automatic logic [pdd_pkg::LETTER_W-1:0] sq_at(int row, int col);
		return key_sq[pdd_pkg::LETTER_W*(pdd_pkg::SIDE*row+col) +: pdd_pkg::LETTER_W];
	endfunction

	// Last matching entry wins; a letter not in the square sits at row 0 col 0.
	function automatic int find_cell(logic [pdd_pkg::LETTER_W-1:0] letter);
		int pos;
		pos = 0;
		for (int k = 0; k < pdd_pkg::CELLS; k++) begin
			if (key_sq[pdd_pkg::LETTER_W*k +: pdd_pkg::LETTER_W] == letter) begin
				pos = k;
			end
		end
		return pos;
	endfunction

	function automatic void decipher_pair(input logic [pdd_pkg::LETTER_W-1:0] a,
			input logic [pdd_pkg::LETTER_W-1:0] b,
			output logic [pdd_pkg::LETTER_W-1:0] pa,
			output logic [pdd_pkg::LETTER_W-1:0] pb);
		int ka, kb, ra, ca, rb, cb;
		ka = find_cell((a == pdd_pkg::CODE_J) ? pdd_pkg::CODE_I : a);
		kb = find_cell((b == pdd_pkg::CODE_J) ? pdd_pkg::CODE_I : b);
		ra = ka / pdd_pkg::SIDE;
		ca = ka % pdd_pkg::SIDE;
		rb = kb / pdd_pkg::SIDE;
		cb = kb % pdd_pkg::SIDE;
		if (ra == rb) begin
			// same row: step left with wrap
			pa = sq_at(ra, (ca + pdd_pkg::SIDE - 1) % pdd_pkg::SIDE);
			pb = sq_at(rb, (cb + pdd_pkg::SIDE - 1) % pdd_pkg::SIDE);
		end else if (ca == cb) begin
			// same column: step up with wrap
			pa = sq_at((ra + pdd_pkg::SIDE - 1) % pdd_pkg::SIDE, ca);
			pb = sq_at((rb + pdd_pkg::SIDE - 1) % pdd_pkg::SIDE, cb);
		end else begin
			// rectangle: swap columns
			pa = sq_at(ra, cb);
			pb = sq_at(rb, ca);
		end
	endfunction

	// The partner decrypted from the pad is dropped.
	function automatic logic [pdd_pkg::LETTER_W-1:0] decipher_padded(
			logic [pdd_pkg::LETTER_W-1:0] a);
		logic [pdd_pkg::LETTER_W-1:0] pa, pb;
		decipher_pair(a, pad_code, pa, pb);
		return pa;
	endfunction

	function automatic void owe_plain(logic [pdd_pkg::LETTER_W-1:0] letter, logic fin);
		plain_t p;
		p.letter = letter;
		p.fin    = fin;
		owed_q[owed_wr % OWED_DEPTH] = p;
		owed_wr++;
	endfunction

	// One accepted cipher letter: update pairing state, queue its plaintext.
	function automatic void predict_plain(logic [pdd_pkg::LETTER_W-1:0] c, logic fin);
		logic [pdd_pkg::LETTER_W-1:0] p0, p1;
		if (!held_busy) begin
			if (fin) begin
				// odd final letter: padded, flagged final
				owe_plain(decipher_padded(c), 1'b1);
			end else begin
				held_code = c;
				held_busy = 1'b1;
			end
		end else if (held_code == c) begin
			// doubled letter: held one goes out padded, new one takes its place
			owe_plain(decipher_padded(held_code), 1'b0);
			if (fin) begin
				owe_plain(decipher_padded(c), 1'b1);
				held_busy = 1'b0;
				held_code = '0;
			end
		end else begin
			decipher_pair(held_code, c, p0, p1);
			owe_plain(p0, 1'b0);
			owe_plain(p1, fin);
			held_busy = 1'b0;
			held_code = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void flag_mismatch(string what, plain_t want, plain_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected letter %0d final %0b, got letter %0d final %0b",
				$time, what, want.letter, want.fin, got.letter, got.fin);
		end
	endfunction

	always @(posedge clk) begin
		plain_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			got.letter = plain_letter;
			got.fin    = final_result;
			if (owed_wr == owed_rd) begin
				flag_mismatch("result with none outstanding", '0, got);
			end else begin
				want = owed_q[owed_rd % OWED_DEPTH];
				owed_rd++;
				if (want.letter !== got.letter) begin
					flag_mismatch("plain_letter", want, got);
				end
				if (want.fin !== got.fin) begin
					flag_mismatch("final_result", want, got);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall runs, plus a long hold when a test asks for one
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (run_left == 0) begin
				run_left  = $urandom_range(1, 6);
				run_stall = ($urandom_range(0, 99) < stall_pct);
			end
			run_left--;
			out_stall <= run_stall;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any accepted item on any channel counts as progress
	// ------------------------------------------------------------------

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (in_valid && in_stall) begin
				backpressured++;
			end
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("playfair_digraph_decrypt: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one letter; bursts of random length with random gaps between them.
	// Valid stays high across a burst and drops only when a gap starts or wait_idle runs.
	task automatic send_letter(input logic [pdd_pkg::LETTER_W-1:0] c, input logic eot);
		int gap;
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, gap_max);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid      <= 1'b1;
		cipher_letter <= c;
		end_of_text   <= eot;
		do @(posedge clk); while (in_stall);
		predict_plain(c, eot);
		letters_sent++;
	endtask

	// Random message ending in end_of_text; doubled letters and i/j pairs
	// are pushed in on purpose since uniform letters seldom produce them.
	task automatic send_message(input int len);
		logic [pdd_pkg::LETTER_W-1:0] c, prev;
		int r;
		prev = '0;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (i > 0 && r < 12) begin
				c = prev;
			end else if (i > 0 && r < 17) begin
				c = (prev == pdd_pkg::CODE_I) ? pdd_pkg::CODE_J : pdd_pkg::CODE_I;
			end else begin
				c = pdd_pkg::LETTER_W'($urandom_range(0, 25));
			end
			send_letter(c, i == len - 1);
			prev = c;
		end
	endtask

	// Input quiet and every owed result back, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (owed_wr != owed_rd) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// cfg_valid is left high so back-to-back writes need no toggle.
	task automatic cfg_write(input pdd_pkg::cfg_idx_t idx,
			input logic [pdd_pkg::ROWS2_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pdd_pkg::CFG_ROWS01: key_sq[0 +: pdd_pkg::ROWS2_W] = data;
			pdd_pkg::CFG_ROWS23: key_sq[pdd_pkg::ROWS2_W +: pdd_pkg::ROWS2_W] = data;
			pdd_pkg::CFG_ROW4:
				key_sq[2*pdd_pkg::ROWS2_W +: pdd_pkg::ROW1_W] = data[pdd_pkg::ROW1_W-1:0];
			pdd_pkg::CFG_PAD:    pad_code = data[pdd_pkg::LETTER_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all four registers; junk puts random bits above the narrow fields.
	task automatic load_square(input logic [pdd_pkg::SQ_W-1:0] sq,
			input logic [pdd_pkg::LETTER_W-1:0] pad, input bit junk);
		logic [pdd_pkg::ROWS2_W-1:0] hi;
		hi = junk ? pdd_pkg::ROWS2_W'({$urandom, $urandom}) : '0;
		cfg_write(pdd_pkg::CFG_ROWS01, sq[0 +: pdd_pkg::ROWS2_W]);
		cfg_write(pdd_pkg::CFG_ROWS23, sq[pdd_pkg::ROWS2_W +: pdd_pkg::ROWS2_W]);
		cfg_write(pdd_pkg::CFG_ROW4, {hi[pdd_pkg::ROWS2_W-pdd_pkg::ROW1_W-1:0],
			sq[2*pdd_pkg::ROWS2_W +: pdd_pkg::ROW1_W]});
		cfg_write(pdd_pkg::CFG_PAD, {hi[pdd_pkg::ROWS2_W-pdd_pkg::LETTER_W-1:0], pad});
		cfg_valid <= 1'b0;
		squares_loaded++;
	endtask

	// Proper key square: the 25 letters other than j in random order.
	function automatic logic [pdd_pkg::SQ_W-1:0] shuffled_square();
		logic [pdd_pkg::LETTER_W-1:0] deck[pdd_pkg::CELLS];
		logic [pdd_pkg::LETTER_W-1:0] t;
		logic [pdd_pkg::SQ_W-1:0]     sq;
		int                           j;
		for (int k = 0; k < pdd_pkg::CELLS; k++) begin
			deck[k] = (k < pdd_pkg::CODE_J) ? pdd_pkg::LETTER_W'(k) :
				pdd_pkg::LETTER_W'(k + 1);
		end
		for (int k = pdd_pkg::CELLS - 1; k > 0; k--) begin
			j       = $urandom_range(0, k);
			t       = deck[k];
			deck[k] = deck[j];
			deck[j] = t;
		end
		for (int k = 0; k < pdd_pkg::CELLS; k++) begin
			sq[pdd_pkg::LETTER_W*k +: pdd_pkg::LETTER_W] = deck[k];
		end
		return sq;
	endfunction

	// Broken square: random 5-bit codes, so duplicates, gaps and codes above z.
	function automatic logic [pdd_pkg::SQ_W-1:0] scrambled_square();
		logic [pdd_pkg::SQ_W-1:0] sq;
		for (int k = 0; k < pdd_pkg::CELLS; k++) begin
			sq[pdd_pkg::LETTER_W*k +: pdd_pkg::LETTER_W] =
				pdd_pkg::LETTER_W'($urandom_range(0, 31));
		end
		return sq;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default square "secur ityab dfghk lmnop qvwxz", default pad x.
	task automatic test_default_square();
		gap_max   = 3;
		stall_pct = 20;
		send_letter(ltr("s"), 1'b0);  // same row
		send_letter(ltr("r"), 1'b0);
		send_letter(ltr("e"), 1'b0);  // same column
		send_letter(ltr("t"), 1'b0);
		send_letter(ltr("a"), 1'b0);  // rectangle, lowest and highest codes
		send_letter(ltr("z"), 1'b0);
		send_letter(ltr("i"), 1'b0);  // i against j: unequal codes, one cell
		send_letter(ltr("j"), 1'b0);
		send_letter(ltr("j"), 1'b0);  // j folds onto i
		send_letter(ltr("k"), 1'b0);
		send_letter(ltr("l"), 1'b0);  // doubled letter, then a pair
		send_letter(ltr("l"), 1'b0);
		send_letter(ltr("n"), 1'b0);
		send_letter(ltr("o"), 1'b0);  // doubled letter at end of text
		send_letter(ltr("o"), 1'b1);
		send_letter(ltr("z"), 1'b1);  // lone final letter
		send_letter(ltr("w"), 1'b0);  // pair closed by end of text
		send_letter(ltr("x"), 1'b1);
		send_letter(ltr("x"), 1'b1);  // lone pad letter padded with itself
		wait_idle();
	endtask

	// All-zero and all-ones squares, pad at both ends of its range.
	task automatic test_square_extremes();
		load_square('0, 5'd0, 1'b0);
		send_letter(ltr("a"), 1'b0);  // every cell matches a; last one wins
		send_letter(ltr("z"), 1'b0);
		send_letter(ltr("a"), 1'b0);
		send_letter(ltr("a"), 1'b1);
		send_letter(ltr("b"), 1'b1);
		wait_idle();
		load_square('1, 5'd25, 1'b1);
		send_letter(ltr("z"), 1'b0);  // nothing matches; codes above z come out
		send_letter(ltr("a"), 1'b0);
		send_letter(ltr("y"), 1'b1);
		wait_idle();
		load_square({pdd_pkg::ROW4_RESET, pdd_pkg::ROWS23_RESET, pdd_pkg::ROWS01_RESET},
			5'd25, 1'b0);
		send_letter(ltr("d"), 1'b0);
		send_letter(ltr("d"), 1'b0);
		send_letter(ltr("k"), 1'b0);
		send_letter(ltr("z"), 1'b1);
		wait_idle();
	endtask

	// Bulk of the run: random squares and pads under varying idling mixes.
	task automatic test_random_squares();
		logic [pdd_pkg::SQ_W-1:0] sq;
		int                       target;
		for (int s = 0; s < 4; s++) begin
			sq = (s == 3) ? scrambled_square() : shuffled_square();
			load_square(sq, pdd_pkg::LETTER_W'($urandom_range(0, 25)), s[0]);
			case (s % 3)
				0: begin gap_max = 6; stall_pct = 30; end
				1: begin gap_max = 0; stall_pct = 0;  end
				default: begin gap_max = 3; stall_pct = 60; end
			endcase
			target = letters_sent + 110;
			while (letters_sent < target) begin
				send_message($urandom_range(1, 12));
			end
			wait_idle();
		end
	endtask

	// Receiver holds off while letters keep coming, so the job queue fills
	// and in_stall rises; then the sender stops until everything drains.
	task automatic test_receiver_hold();
		int target;
		gap_max   = 0;
		stall_pct = 0;
		hold_token++;
		target = letters_sent + 40;
		while (letters_sent < target) begin
			send_message($urandom_range(2, 12));
		end
		wait_idle();
		gap_max   = 4;
		stall_pct = 25;
		send_message(7);
		send_message(4);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_default_square();
		test_square_extremes();
		test_random_squares();
		test_receiver_hold();
		wait_idle();
		if (owed_wr != owed_rd) begin
			$display("%0d owed results never came out", owed_wr - owed_rd);
			mismatches++;
		end
		$display("covered %0d cipher letters and %0d plaintext results over %0d key squares",
			letters_sent, results_seen, squares_loaded + 1);
		$display("input was held back %0d cycles; %0d mismatches counted",
			backpressured, mismatches);
		if (mismatches == 0) begin
			$display("playfair_digraph_decrypt: match");
		end else begin
			$display("playfair_digraph_decrypt: mismatch");
		end
		$finish;
	end

endmodule
